// ===== rtl/core/dtf_pkg.sv =====
// Shared constants, types and elaboration-time conversion functions for the thermistor block.
`default_nettype none

package dtf_pkg;

    localparam int NUM_CH    = 2;
    localparam int CH_IN     = 0;
    localparam int CH_RETURN = 1;

    localparam int SAMPLE_W   = 10;
    localparam int TEMP_W     = 14;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    localparam int WINDOW   = 50;
    localparam int ADC_BITS = 10;
    localparam int BETA     = 3995;

    localparam logic [63:0] REF_RES_IN     = 64'd10010;
    localparam logic [63:0] REF_RES_RETURN = 64'd9975;
    localparam logic [63:0] NOMINAL_RES    = 64'd10061;
    localparam logic [63:0] REF_RES [NUM_CH] = '{REF_RES_IN, REF_RES_RETURN};

    localparam logic [63:0] CODE_MAX = (64'd1 << ADC_BITS) - 64'd1;

    localparam longint T_MAX   = 8191;
    localparam longint T_MIN   = -8192;
    localparam longint T_END   = -4596;
    localparam longint T_SCALE = longint'(10) <<< 20;

    // Ring position, running sum and the reciprocal used for the divide by the window length.
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam int TABLE_DEPTH = 1 << SAMPLE_W;

    typedef logic [SAMPLE_W-1:0]      t_sample;
    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [SUM_W-1:0]         t_sum;

    // Unsigned quotient by restoring division, one bit per step.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [63:0] q;
        r = 64'd0;
        q = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // (a * b) >> 60, truncated to 64 bits.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // num / den in Q60 for num < den.
    function automatic logic [63:0] frac_q60(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] r;
        logic [63:0] q;
        r = num;
        q = 64'd0;
        for (int i = 0; i < 60; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // ln(n/d) for d <= n < 2d in Q60, from the atanh series.
    function automatic logic [63:0] ln_small_q60(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] k;
        z    = frac_q60(n - d, n + d);
        z2   = mul_q60(z, z);
        term = z;
        acc  = 64'd0;
        for (k = 64'd1; k < 64'd90 && term != 64'd0; k = k + 64'd2) begin
            acc  = acc + udiv64(term, k);
            term = mul_q60(term, z2);
        end
        return acc << 1;
    endfunction

    // ln(n/d) in Q40 for positive n and d.
    function automatic longint ln_q40(input logic [63:0] n_in, input logic [63:0] d_in);
        logic [63:0] n;
        logic [63:0] d;
        longint      k;
        longint      ln2;
        longint      frac;
        n   = n_in;
        d   = d_in;
        k   = 0;
        ln2 = longint'(ln_small_q60(64'd2, 64'd1) >> 20);
        if (n >= d) begin
            while (n >= (d << 1)) begin
                d = d << 1;
                k = k + 1;
            end
        end else begin
            while (n < d) begin
                n = n << 1;
                k = k - 1;
            end
        end
        frac = longint'(ln_small_q60(n, d) >> 20);
        return k * ln2 + frac;
    endfunction

    // Temperature in tenths of a degree F for one average code and reference resistor.
    function automatic t_temp to_degf(input logic [63:0] code, input logic [63:0] rref);
        logic [63:0] c;
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] dd;
        logic [63:0] dbit;
        longint      x;
        longint      den;
        longint      p;
        longint      t;
        logic        sat;
        c = code;
        if (c > CODE_MAX) begin
            c = CODE_MAX;
        end
        if (c == 64'd0 || c == CODE_MAX) begin
            return TEMP_W'(T_END);
        end
        x   = ln_q40(rref * c, NOMINAL_RES * (CODE_MAX - c));
        den = longint'(29815) * x + (longint'(100 * BETA) <<< 40);
        if (den <= 0) begin
            return TEMP_W'(T_MAX);
        end
        dd  = 64'(den);
        a   = 64'd18 * 64'(BETA) * 64'd29815;
        r   = 64'd0;
        q   = 64'd0;
        sat = 1'b0;
        // Long division of a * 2^60 by the denominator, one quotient bit per step.
        for (int i = 63; i >= -60; i--) begin
            if (!sat) begin
                dbit = (i >= 0) ? ((a >> i) & 64'd1) : 64'd0;
                r    = (r << 1) | dbit;
                q    = q << 1;
                if (r >= dd) begin
                    r = r - dd;
                    q = q | 64'd1;
                end
                if (q > (64'd1 << 50)) begin
                    sat = 1'b1;
                end
            end
        end
        if (sat) begin
            return TEMP_W'(T_MAX);
        end
        p = longint'(q) * 10 - (longint'(45967) <<< 20);
        // Truncation toward zero on the magnitude.
        if (p < 0) begin
            t = -longint'(udiv64(64'(-p), 64'(T_SCALE)));
        end else begin
            t = longint'(udiv64(64'(p), 64'(T_SCALE)));
        end
        if (t > T_MAX) begin
            t = T_MAX;
        end
        if (t < T_MIN) begin
            t = T_MIN;
        end
        return TEMP_W'(t);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtf_if.sv =====
// Valid/ready channel interfaces for the sample input and the temperature result.
`default_nettype none

interface dtf_in_if import dtf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;
    t_sample sample_return;

    modport source (output valid, output sample_in, output sample_return, input ready);
    modport sink   (input valid, input sample_in, input sample_return, output ready);
endinterface

interface dtf_out_if import dtf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample avg_in;
    t_sample avg_return;
    t_temp   temp_in;
    t_temp   temp_return;
    logic    fault_in;
    logic    fault_return;

    modport source (output valid, output avg_in, output avg_return, output temp_in,
                    output temp_return, output fault_in, output fault_return, input ready);
    modport sink   (input valid, input avg_in, input avg_return, input temp_in,
                    input temp_return, input fault_in, input fault_return, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dtf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/dual_thermistor_average_to_degf.sv =====
// Two-channel thermistor window average and conversion to tenths of a degree Fahrenheit.
//
// Each input transaction carries one ADC code per channel (solar inlet, pool return). Every
// channel keeps the last 50 codes in a small RAM and a running sum; the result transaction
// gives the truncated window average, the temperature in tenths of a degree F from a
// 1024-entry Beta-equation table per channel (built at elaboration), and a fault flag for
// averages of 0 or full scale. The block accepts one transaction per clock unless a stalled
// result holds it: the window RAM is read when a transaction is taken, the sum is written back
// when that transaction leaves the first stage, then the divide by the window length and the
// table lookup each take one registered stage. The window starts out as all zeros after reset
// through per-slot valid bits, so no clearing pass is needed. A stalled result holds the whole
// pipeline.
`default_nettype none

module dual_thermistor_average_to_degf import dtf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtf_in_if.sink    i_sample,
    dtf_out_if.source o_result
);

    logic              advance;
    logic              accept;
    logic              write_en;
    logic              fwd_now;
    logic              old_valid_now;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [SLOT_W-1:0] r1_slot;
    logic [WINDOW-1:0] r_vbits;
    logic              r1_valid;
    logic              r1_old_valid;
    logic              r1_fwd;
    logic              r2_valid;
    logic              r3_valid;
    logic              r_out_valid;

    t_sample samp    [NUM_CH];
    t_sample avg_q   [NUM_CH];
    t_temp   temp_q  [NUM_CH];
    logic    fault_q [NUM_CH];

    assign advance        = !r_out_valid || o_result.ready;
    assign accept         = i_sample.valid && advance;
    assign i_sample.ready = advance;
    assign write_en       = advance && r1_valid;

    // With a one-entry window the write-back and the next read hit the same slot.
    assign fwd_now       = write_en && (r1_slot == r_slot);
    assign old_valid_now = r_vbits[r_slot] || fwd_now;
    assign n_slot        = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    assign samp[CH_IN]     = i_sample.sample_in;
    assign samp[CH_RETURN] = i_sample.sample_return;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_vbits     <= '0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_slot <= n_slot;
            end
            if (write_en) begin
                r_vbits[r1_slot] <= 1'b1;
            end
            if (advance) begin
                r1_valid    <= i_sample.valid;
                r2_valid    <= r1_valid;
                r3_valid    <= r2_valid;
                r_out_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_slot      <= r_slot;
            r1_old_valid <= old_valid_now;
            r1_fwd       <= fwd_now;
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        t_sample           r1_sample;
        t_sample           r1_fwd_data;
        t_sample           ram_rdata;
        t_sample           old_sample;
        t_sum              r_sum;
        t_sum              n_sum;
        t_sum              r2_sum;
        logic [PROD_W-1:0] prod;
        t_sample           r3_avg;
        t_sample           r_avg;
        t_temp             r_temp;
        logic              r_fault;
        t_temp             rom [TABLE_DEPTH];

        for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
            localparam t_temp ENTRY = to_degf(64'(g), REF_RES[c]);
            assign rom[g] = ENTRY;
        end

        dtf_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (WINDOW)
        ) u_window (
            .i_clk   (i_clk),
            .i_we    (write_en),
            .i_waddr (r1_slot),
            .i_wdata (r1_sample),
            .i_re    (accept),
            .i_raddr (r_slot),
            .o_rdata (ram_rdata)
        );

        assign old_sample = r1_fwd ? r1_fwd_data : (r1_old_valid ? ram_rdata : '0);
        assign n_sum      = r_sum - SUM_W'(old_sample) + SUM_W'(r1_sample);
        assign prod       = PROD_W'(r2_sum) * PROD_W'(RECIP);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum <= '0;
            end else if (write_en) begin
                r_sum <= n_sum;
            end
        end

        always_ff @(posedge i_clk) begin
            if (accept) begin
                r1_sample   <= samp[c];
                r1_fwd_data <= r1_sample;
            end
            if (advance) begin
                r2_sum  <= n_sum;
                r3_avg  <= prod[DIV_SHIFT +: SAMPLE_W];
                r_avg   <= r3_avg;
                r_temp  <= rom[r3_avg];
                r_fault <= (r3_avg == '0) || (64'(r3_avg) >= CODE_MAX);
            end
        end

        assign avg_q[c]   = r_avg;
        assign temp_q[c]  = r_temp;
        assign fault_q[c] = r_fault;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.avg_in       = avg_q[CH_IN];
    assign o_result.avg_return   = avg_q[CH_RETURN];
    assign o_result.temp_in      = temp_q[CH_IN];
    assign o_result.temp_return  = temp_q[CH_RETURN];
    assign o_result.fault_in     = fault_q[CH_IN];
    assign o_result.fault_return = fault_q[CH_RETURN];

endmodule

`default_nettype wire

// ===== tb/dual_thermistor_average_to_degf_test.sv =====
// Self-checking testbench for the two-channel thermistor window average and degF conversion.
module dual_thermistor_average_to_degf_test import dtf_pkg::*; ();

    localparam int N_RANDOM    = 1300;
    localparam int N_DIRECTED  = 18;
    localparam int DRAIN_EVERY = 650;
    localparam int IDLE_LIMIT  = 4000;
    localparam int END_CYCLES  = 16;

    typedef struct packed {
        t_sample avg_in;
        t_sample avg_return;
        t_temp   temp_in;
        t_temp   temp_return;
        logic    fault_in;
        logic    fault_return;
    } t_reading;

    typedef struct {
        t_sample code_in;
        t_sample code_return;
        bit      drain;
    } t_sample_pair;

    logic clk;
    logic rst_n;

    dtf_in_if  sample_ch ();
    dtf_out_if result_ch ();

    dual_thermistor_average_to_degf i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch)
    );

    t_sample_pair pending_pairs [$];
    t_reading     expected_readings [$];
    int           error_count;
    int           queued_count;

    // Predicted conversion for every average code, per channel.
    t_temp        degf_lut [NUM_CH][TABLE_DEPTH];
    t_sample      ring [NUM_CH][WINDOW];
    logic [15:0]  ring_sum [NUM_CH];
    logic [5:0]   ring_slot [NUM_CH];

    always #2 clk = ~clk;

    task automatic flag_error(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // (a * b) >> 60 with the full 128-bit product.
    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return full[123:60];
    endfunction

    // Fraction num/den in Q60 by restoring division, num < den.
    function automatic logic [63:0] q60_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = num;
        quo = '0;
        repeat (60) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(n/d) in Q60 for d <= n < 2d, as twice the atanh series of (n-d)/(n+d).
    function automatic logic [63:0] atanh_log_q60(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] z;
        logic [63:0] z_sq;
        logic [63:0] term;
        logic [63:0] acc;
        int          k;
        z    = q60_ratio(n - d, n + d);
        z_sq = q60_product(z, z);
        term = z;
        acc  = '0;
        k    = 1;
        while (k < 90 && term != 0) begin
            acc  = acc + term / 64'(k);
            term = q60_product(term, z_sq);
            k    = k + 2;
        end
        return acc << 1;
    endfunction

    // ln(n/d) in Q40: scale by powers of two into [d, 2d), then the series.
    function automatic longint log_ratio_q40(input logic [63:0] n_in, input logic [63:0] d_in);
        logic [63:0] n;
        logic [63:0] d;
        longint      octaves;
        longint      ln2;
        n       = n_in;
        d       = d_in;
        octaves = 0;
        ln2     = longint'(atanh_log_q60(64'd2, 64'd1) >> 20);
        if (n >= d) begin
            while (n >= (d << 1)) begin
                d = d << 1;
                octaves++;
            end
        end else begin
            while (n < d) begin
                n = n << 1;
                octaves--;
            end
        end
        return octaves * ln2 + longint'(atanh_log_q60(n, d) >> 20);
    endfunction

    // Beta equation to tenths of a degree F, truncated toward zero.
    function automatic t_temp beta_degf(input int code, input logic [63:0] rref);
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [63:0] rem;
        logic [63:0] quo;
        logic        next_bit;
        longint      log_term;
        longint      den;
        longint      scaled;
        longint      tenths;
        if (code == 0 || code == SAMPLE_MAX) begin
            return t_temp'(T_END);
        end
        log_term = log_ratio_q40(rref * 64'(code), NOMINAL_RES * (CODE_MAX - 64'(code)));
        den = longint'(29815) * log_term + (longint'(100 * BETA) <<< 40);
        if (den <= 0) begin
            return t_temp'(T_MAX);
        end
        divisor  = 64'(den);
        dividend = 64'd18 * 64'(BETA) * 64'd29815;
        rem = '0;
        quo = '0;
        // 18*T in Q20: dividend * 2^60 / den, giving up once the quotient is out of range.
        for (int i = 63; i >= -60; i--) begin
            next_bit = 1'b0;
            if (i >= 0) begin
                next_bit = dividend[i];
            end
            rem = {rem[62:0], next_bit};
            quo = quo << 1;
            if (rem >= divisor) begin
                rem = rem - divisor;
                quo[0] = 1'b1;
            end
            if (quo > (64'd1 << 50)) begin
                return t_temp'(T_MAX);
            end
        end
        scaled = longint'(quo) * 10 - (longint'(45967) <<< 20);
        tenths = scaled / (longint'(10) <<< 20);
        if (tenths > T_MAX) begin
            tenths = T_MAX;
        end
        if (tenths < T_MIN) begin
            tenths = T_MIN;
        end
        return t_temp'(tenths);
    endfunction

    // Pushes both codes into their windows and forms the expected reading.
    task automatic predict_reading(input t_sample code_in, input t_sample code_return,
                                   output t_reading reading);
        t_sample code [NUM_CH];
        t_sample avg [NUM_CH];
        code[CH_IN]     = code_in;
        code[CH_RETURN] = code_return;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            ring_sum[ch] = ring_sum[ch] - ring[ch][ring_slot[ch]] + code[ch];
            ring[ch][ring_slot[ch]] = code[ch];
            ring_slot[ch] = (ring_slot[ch] == WINDOW - 1) ? 6'd0 : ring_slot[ch] + 6'd1;
            avg[ch] = t_sample'(ring_sum[ch] / WINDOW);
        end
        reading.avg_in       = avg[CH_IN];
        reading.avg_return   = avg[CH_RETURN];
        reading.temp_in      = degf_lut[CH_IN][avg[CH_IN]];
        reading.temp_return  = degf_lut[CH_RETURN][avg[CH_RETURN]];
        reading.fault_in     = (avg[CH_IN] == 0) || (avg[CH_IN] == SAMPLE_MAX);
        reading.fault_return = (avg[CH_RETURN] == 0) || (avg[CH_RETURN] == SAMPLE_MAX);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    // The first random transaction and one in the middle wait for the pipeline to drain.
    task automatic queue_pair(input int code_in, input int code_return, input int n_directed);
        t_sample_pair pair;
        pair.code_in     = t_sample'(code_in);
        pair.code_return = t_sample'(code_return);
        pair.drain       = (queued_count == n_directed) ||
                           (queued_count == n_directed + DRAIN_EVERY);
        pending_pairs.push_back(pair);
        queued_count++;
    endtask

    function automatic int clamp_code(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > SAMPLE_MAX) begin
            return SAMPLE_MAX;
        end
        return v;
    endfunction

    function automatic int pick_level();
        case ($urandom_range(0, 7))
            0: begin
                return 0;
            end
            1: begin
                return SAMPLE_MAX;
            end
            2: begin
                return 1;
            end
            3: begin
                return SAMPLE_MAX - 1;
            end
            default: begin
                return $urandom_range(0, SAMPLE_MAX);
            end
        endcase
    endfunction

    // Driver: bursts of transactions separated by random gaps.
    bit offer_pending;
    int burst_left;
    int gap_left;

    always @(posedge clk) begin
        t_sample_pair pair;
        t_reading     reading;
        if (!rst_n) begin
            sample_ch.valid <= 1'b0;
            offer_pending = 1'b0;
            burst_left    = 1;
            gap_left      = 0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                predict_reading(sample_ch.sample_in, sample_ch.sample_return, reading);
                expected_readings.push_back(reading);
                offer_pending = 1'b0;
            end
            if (!offer_pending) begin
                if (gap_left > 0) begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end else if (pending_pairs.size() > 0 &&
                             !(pending_pairs[0].drain && expected_readings.size() != 0)) begin
                    pair = pending_pairs.pop_front();
                    sample_ch.sample_in     <= pair.code_in;
                    sample_ch.sample_return <= pair.code_return;
                    sample_ch.valid         <= 1'b1;
                    offer_pending = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and stalls in modes that change over time.
    int stall_mode;
    int mode_left;
    int stall_phase;

    always @(posedge clk) begin
        t_reading got;
        t_reading want;
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_mode  = 0;
            mode_left   = 0;
            stall_phase = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got.avg_in       = result_ch.avg_in;
                got.avg_return   = result_ch.avg_return;
                got.temp_in      = result_ch.temp_in;
                got.temp_return  = result_ch.temp_return;
                got.fault_in     = result_ch.fault_in;
                got.fault_return = result_ch.fault_return;
                if (expected_readings.size() == 0) begin
                    flag_error("result transaction with no expected reading");
                end else begin
                    want = expected_readings.pop_front();
                    check_field("avg_in", got.avg_in, want.avg_in);
                    check_field("avg_return", got.avg_return, want.avg_return);
                    check_field("temp_in", got.temp_in, want.temp_in);
                    check_field("temp_return", got.temp_return, want.temp_return);
                    check_field("fault_in", got.fault_in, want.fault_in);
                    check_field("fault_return", got.fault_return, want.fault_return);
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(40, 300);
            end else begin
                mode_left--;
            end
            stall_phase = (stall_phase == 6) ? 0 : stall_phase + 1;
            case (stall_mode)
                0: begin
                    result_ch.ready <= 1'b1;
                end
                1: begin
                    result_ch.ready <= ($urandom_range(0, 9) < 7);
                end
                2: begin
                    result_ch.ready <= (stall_phase >= 3);
                end
                default: begin
                    result_ch.ready <= ($urandom_range(0, 15) == 0);
                end
            endcase
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    int idle_cycles;

    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int directed [N_DIRECTED][2];
        int random_count;
        int kind;
        int len;
        int level_in;
        int level_return;
        int jitter;
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.sample_in     = '0;
        sample_ch.sample_return = '0;
        result_ch.ready         = 1'b0;
        error_count             = 0;
        queued_count            = 0;
        idle_cycles             = 0;

        for (int ch = 0; ch < NUM_CH; ch++) begin
            ring_sum[ch]  = '0;
            ring_slot[ch] = '0;
            for (int s = 0; s < WINDOW; s++) begin
                ring[ch][s] = '0;
            end
            for (int code = 0; code < TABLE_DEPTH; code++) begin
                degf_lut[ch][code] = beta_degf(code, REF_RES[ch]);
            end
        end

        // Code extremes on each channel, alternating bit patterns, mid scale.
        directed = '{'{0, 0}, '{1023, 1023}, '{1023, 0}, '{0, 1023}, '{1, 1022},
                     '{1022, 1}, '{512, 511}, '{341, 682}, '{682, 341}, '{1023, 1023},
                     '{1023, 1023}, '{0, 0}, '{1, 1}, '{1022, 1022}, '{1023, 512},
                     '{768, 256}, '{1023, 1023}, '{1023, 1023}};
        foreach (directed[i]) begin
            queue_pair(directed[i][0], directed[i][1], N_DIRECTED);
        end

        // Mostly steady levels held for at least the window length, so averages settle on
        // any code including both fault ends; then drifts, noise and rail toggling.
        random_count = 0;
        while (random_count < N_RANDOM) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                len          = $urandom_range(50, 75);
                level_in     = pick_level();
                level_return = pick_level();
                jitter       = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
                repeat (len) begin
                    queue_pair(clamp_code(level_in + $urandom_range(0, 2 * jitter) - jitter),
                               clamp_code(level_return + $urandom_range(0, 2 * jitter) - jitter),
                               N_DIRECTED);
                    random_count++;
                end
            end else if (kind <= 6) begin
                len          = $urandom_range(20, 60);
                level_in     = $urandom_range(0, SAMPLE_MAX);
                level_return = $urandom_range(0, SAMPLE_MAX);
                repeat (len) begin
                    level_in     = clamp_code(level_in + $urandom_range(0, 8) - 4);
                    level_return = clamp_code(level_return + $urandom_range(0, 8) - 4);
                    queue_pair(level_in, level_return, N_DIRECTED);
                    random_count++;
                end
            end else if (kind <= 8) begin
                len = $urandom_range(5, 30);
                repeat (len) begin
                    queue_pair($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                               N_DIRECTED);
                    random_count++;
                end
            end else begin
                len = $urandom_range(10, 30);
                repeat (len) begin
                    queue_pair($urandom_range(0, 1) * SAMPLE_MAX, $urandom_range(0, 1) * SAMPLE_MAX,
                               N_DIRECTED);
                    random_count++;
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || offer_pending || expected_readings.size() != 0) begin
            @(posedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
